// ===== rtl/led_matrix_row_scanner_unit_macros.svh =====
// Assertion macros shared by the row scanner checker.
`ifndef LED_MATRIX_ROW_SCANNER_UNIT_MACROS_SVH
`define LED_MATRIX_ROW_SCANNER_UNIT_MACROS_SVH

// Concurrent check, switched off while reset is high.
`define LMRS_ASSERT(lbl, clock, reset, prop, msg) \
  lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent check that also holds across reset.
`define LMRS_ASSERT_ALWAYS(lbl, clock, prop, msg) \
  lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== rtl/lmrs_pkg.sv =====
// Package: shared constants and codes of the LED matrix row scanner.
package lmrs_pkg;

  localparam int DEF_ROW_COUNT   = 7;
  localparam int DEF_COLUMN_BITS = 30;

  // Fixed field widths.
  localparam int REQ_W    = 2;
  localparam int IDX_W    = 3;
  localparam int WORD_W   = 30;
  localparam int LIGHT_W  = 10;
  localparam int ENABLE_W = 7;
  localparam int THR_W    = 10;
  localparam int PER_W    = 17;
  localparam int LEVEL_W  = 2;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WRITE  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_TICK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SAMPLE = 2'd2;

  // Brightness levels.
  localparam logic [LEVEL_W-1:0] LEVEL_BRIGHT = 2'd0;
  localparam logic [LEVEL_W-1:0] LEVEL_MID    = 2'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_DARK   = 2'd2;

  // Register indexes (byte address = 4 * index).
  localparam logic [2:0] REG_BRIGHT_THR = 3'd0;
  localparam logic [2:0] REG_DIM_THR    = 3'd1;
  localparam logic [2:0] REG_PERIOD0    = 3'd2;
  localparam logic [2:0] REG_PERIOD1    = 3'd3;
  localparam logic [2:0] REG_PERIOD2    = 3'd4;

  // Register reset values.
  localparam logic [THR_W-1:0] RST_BRIGHT_THR = 10'd950;
  localparam logic [THR_W-1:0] RST_DIM_THR    = 10'd800;
  localparam logic [PER_W-1:0] RST_PERIOD0    = 17'd553;
  localparam logic [PER_W-1:0] RST_PERIOD1    = 17'd7373;
  localparam logic [PER_W-1:0] RST_PERIOD2    = 17'd18432;

endpackage

// ===== rtl/lmrs_frame_store.sv =====
// Frame store: synchronous row-word memory with per-row valid bits.
module lmrs_frame_store
  import lmrs_pkg::*;
#(
  parameter int ROW_COUNT   = DEF_ROW_COUNT,
  parameter int COLUMN_BITS = DEF_COLUMN_BITS,
  parameter int ROW_W       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   wr_en,
  input  logic [ROW_W-1:0]       wr_row,
  input  logic [COLUMN_BITS-1:0] wr_word,
  input  logic                   rd_en,
  input  logic [ROW_W-1:0]       rd_row,
  output logic [COLUMN_BITS-1:0] rd_word
);

  logic [COLUMN_BITS-1:0] mem [ROW_COUNT];
  logic [ROW_COUNT-1:0]   row_valid;
  logic [COLUMN_BITS-1:0] rd_data;
  logic                   rd_ok;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (wr_en) begin
      row_valid[wr_row] <= 1'b1;
    end
  end

  // Registered read; an unwritten row reads as zero.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_row];
      rd_ok   <= row_valid[rd_row];
    end
  end

  assign rd_word = rd_ok ? rd_data : '0;

endmodule

// ===== rtl/lmrs_row_shifter.sv =====
// Row shifter: serialises one row word MSB first onto the output channel.
module lmrs_row_shifter
  import lmrs_pkg::*;
#(
  parameter int ROW_COUNT   = DEF_ROW_COUNT,
  parameter int COLUMN_BITS = DEF_COLUMN_BITS,
  parameter int ROW_W       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   load,
  input  logic [ROW_W-1:0]       load_row,
  input  logic [COLUMN_BITS-1:0] load_word,
  output logic                   busy,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   shift_bit,
  output logic [ENABLE_W-1:0]    row_enables,
  output logic                   last
);

  localparam int CNT_W = $clog2(COLUMN_BITS + 1);
  localparam logic [ENABLE_W-1:0] ALL_HIGH = ENABLE_W'((64'd1 << ROW_COUNT) - 64'd1);

  logic                   active;
  logic [CNT_W-1:0]       remaining;
  logic [COLUMN_BITS-1:0] word;
  logic [ROW_W-1:0]       row;
  logic [ENABLE_W-1:0]    row_sel;

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      remaining <= '0;
    end else if (load) begin
      active    <= 1'b1;
      remaining <= CNT_W'(COLUMN_BITS);
    end else if (active && out_ready) begin
      remaining <= remaining - 1'b1;
      if (remaining == CNT_W'(1)) begin
        active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      word <= load_word;
      row  <= load_row;
    end else if (active && out_ready) begin
      word <= word << 1;
    end
  end

  // Rows past the port width have no enable to drop.
  assign row_sel     = ENABLE_W'(32'd1 << row);
  assign busy        = active;
  assign out_valid   = active;
  assign shift_bit   = word[COLUMN_BITS-1];
  assign last        = (remaining == CNT_W'(1));
  assign row_enables = last ? (ALL_HIGH & ~row_sel) : ALL_HIGH;

endmodule

// ===== rtl/led_matrix_row_scanner_unit.sv =====
// Top level of the LED matrix row scanner: request decode, refresh timing, registers.
// Usage
//   Input channel (in_valid/in_ready): one request per transfer. A write
//   request replaces one row word, a light sample sets the brightness level,
//   a tick counts the refresh countdown down. One request per cycle is
//   sustained, except while an expiring tick is held back (see below).
//   When a tick expires the countdown, the current row word is read from the
//   frame store (registered read port) and loaded into the row shifter the
//   cycle after. The output channel (out_valid/out_ready) then carries 30
//   serial bit transfers, MSB first, the last one flagged with last and that
//   row's enable driven low; rows stay blanked before it.
//   The first bit is offered once rd_pending has loaded the read word into the shifter.
//   Writes, samples and non-expiring ticks keep flowing while bits shift
//   out; only an expiring tick is held back until the previous refresh has
//   left the shifter.
//   A stalled receiver freezes the shifter on the current bit; nothing is lost.
// Reset (rst, synchronous): frame store reads as zero (valid bits cleared),
//   row 0, countdown 1, brightness level 2, registers to their defaults.
// Configuration: APB-style port, register i at byte address 4*i, no waits.
module led_matrix_row_scanner_unit
  import lmrs_pkg::*;
#(
  parameter int ROW_COUNT   = DEF_ROW_COUNT,
  parameter int COLUMN_BITS = DEF_COLUMN_BITS
) (
  input  logic                clk,
  input  logic                rst,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [REQ_W-1:0]    req_type,
  input  logic [IDX_W-1:0]    row_index,
  input  logic [WORD_W-1:0]   row_bits,
  input  logic [LIGHT_W-1:0]  light_level,
  // serial bit channel
  output logic                out_valid,
  input  logic                out_ready,
  output logic                shift_bit,
  output logic [ENABLE_W-1:0] row_enables,
  output logic                last
);

  localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

  // Configuration registers.
  logic [THR_W-1:0] bright_thr;
  logic [THR_W-1:0] dim_thr;
  logic [PER_W-1:0] period0;
  logic [PER_W-1:0] period1;
  logic [PER_W-1:0] period2;

  // Scan state.
  logic [ROW_W-1:0]   current_row;
  logic [ROW_W-1:0]   current_row_next;
  logic [PER_W-1:0]   countdown;
  logic [LEVEL_W-1:0] level;
  logic [PER_W-1:0]   period_sel;
  logic [PER_W-1:0]   reload;

  // Read in flight between frame store and shifter.
  logic               rd_pending;
  logic [ROW_W-1:0]   rd_row_q;

  logic                   cfg_wr;
  logic                   in_fire;
  logic                   is_tick;
  logic                   expire;
  logic                   refresh;
  logic                   wr_en;
  logic [COLUMN_BITS-1:0] wr_word;
  logic [COLUMN_BITS-1:0] rd_word;
  logic                   sh_busy;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_thr <= RST_BRIGHT_THR;
      dim_thr    <= RST_DIM_THR;
      period0    <= RST_PERIOD0;
      period1    <= RST_PERIOD1;
      period2    <= RST_PERIOD2;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_BRIGHT_THR: bright_thr <= pwdata[THR_W-1:0];
        REG_DIM_THR:    dim_thr    <= pwdata[THR_W-1:0];
        REG_PERIOD0:    period0    <= pwdata[PER_W-1:0];
        REG_PERIOD1:    period1    <= pwdata[PER_W-1:0];
        REG_PERIOD2:    period2    <= pwdata[PER_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_BRIGHT_THR: prdata = DATA_W'(bright_thr);
      REG_DIM_THR:    prdata = DATA_W'(dim_thr);
      REG_PERIOD0:    prdata = DATA_W'(period0);
      REG_PERIOD1:    prdata = DATA_W'(period1);
      REG_PERIOD2:    prdata = DATA_W'(period2);
      default:        prdata = '0;
    endcase
  end

  // ---------------- request decode ----------------
  // The countdown never drops below one, so one means this tick expires.
  assign is_tick = (req_type == REQ_TICK);
  assign expire  = (countdown == PER_W'(1));

  // Hold an expiring tick while the previous refresh is still in flight.
  assign in_ready = !(is_tick && expire) || (!rd_pending && !sh_busy);
  assign in_fire  = in_valid && in_ready;
  assign refresh  = in_fire && is_tick && expire;

  assign wr_en   = in_fire && (req_type == REQ_WRITE) && (32'(row_index) < ROW_COUNT);
  assign wr_word = COLUMN_BITS'(row_bits);

  // Period for the current level; a zero period counts as one tick.
  always_comb begin
    case (level)
      LEVEL_BRIGHT: period_sel = period0;
      LEVEL_MID:    period_sel = period1;
      default:      period_sel = period2;
    endcase
    reload = (period_sel == '0) ? PER_W'(1) : period_sel;
  end

  assign current_row_next = (32'(current_row) == ROW_COUNT - 1) ? '0 : current_row + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_row <= '0;
      countdown   <= PER_W'(1);
      level       <= LEVEL_DARK;
      rd_pending  <= 1'b0;
    end else begin
      rd_pending <= refresh;
      if (in_fire && (req_type == REQ_SAMPLE)) begin
        // Bright test first, so overlapping thresholds still resolve.
        if (light_level > bright_thr) begin
          level <= LEVEL_BRIGHT;
        end else if (light_level > dim_thr) begin
          level <= LEVEL_MID;
        end else begin
          level <= LEVEL_DARK;
        end
      end
      if (in_fire && is_tick) begin
        if (expire) begin
          current_row <= current_row_next;
          countdown   <= reload;
        end else begin
          countdown <= countdown - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (refresh) begin
      rd_row_q <= current_row;
    end
  end

  // ---------------- frame store ----------------
  // One request per cycle, so a write and the refresh read never share an edge;
  // a write accepted before the tick is already in the array when it is read.
  lmrs_frame_store #(
    .ROW_COUNT   (ROW_COUNT),
    .COLUMN_BITS (COLUMN_BITS),
    .ROW_W       (ROW_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_row  (ROW_W'(row_index)),
    .wr_word (wr_word),
    .rd_en   (refresh),
    .rd_row  (current_row),
    .rd_word (rd_word)
  );

  // ---------------- row shifter ----------------
  lmrs_row_shifter #(
    .ROW_COUNT   (ROW_COUNT),
    .COLUMN_BITS (COLUMN_BITS),
    .ROW_W       (ROW_W)
  ) u_shift (
    .clk         (clk),
    .rst         (rst),
    .load        (rd_pending),
    .load_row    (rd_row_q),
    .load_word   (rd_word),
    .busy        (sh_busy),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shift_bit   (shift_bit),
    .row_enables (row_enables),
    .last        (last)
  );

endmodule

// ===== rtl/lmrs_checker.sv =====
// Port-level checker for the row scanner, bound to the top level.
`include "led_matrix_row_scanner_unit_macros.svh"

module lmrs_checker
  import lmrs_pkg::*;
#(
  parameter int ROW_COUNT = DEF_ROW_COUNT
) (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic                shift_bit,
  input logic [ENABLE_W-1:0] row_enables,
  input logic                last
);

  localparam logic [ENABLE_W-1:0] ALL_HIGH = ENABLE_W'((64'd1 << ROW_COUNT) - 64'd1);

  logic                shifting;
  logic                blanked;
  logic                stall;
  logic                latch_xfer;
  logic [ENABLE_W+1:0] out_bits;

  assign shifting   = out_valid && !last;
  assign blanked    = (row_enables == ALL_HIGH);
  assign stall      = out_valid && !out_ready;
  assign latch_xfer = out_valid && out_ready && last;
  assign out_bits   = {shift_bit, row_enables, last};

  // Rows stay blanked on every bit but the latch bit.
  `LMRS_ASSERT(a_blank_while_shifting, clk, rst, shifting |-> blanked, "row driven early")

  // A stalled bit holds its value.
  `LMRS_ASSERT(a_stall_hold, clk, rst, stall |=> out_valid && $stable(out_bits), "stall broken")

  // A refresh never follows the previous one's latch bit back to back.
  `LMRS_ASSERT(a_gap_after_latch, clk, rst, latch_xfer |=> !out_valid, "no gap after latch")

  // Reset leaves the output channel empty.
  `LMRS_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

endmodule

bind led_matrix_row_scanner_unit lmrs_checker #(.ROW_COUNT(ROW_COUNT)) u_lmrs_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .shift_bit   (shift_bit),
  .row_enables (row_enables),
  .last        (last)
);

// ===== sim/led_matrix_row_scanner_unit_tb.sv =====
// Self-checking testbench for the LED matrix row scanner: directed rows, random phases, scoring.
module led_matrix_row_scanner_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lmrs_pkg::*;

  localparam int ROWS          = DEF_ROW_COUNT;
  localparam int HOLD_CYCLES   = 300;      // long receiver hold-off, forces input backpressure
  localparam int SETTLE_CYCLES = 6;        // block latency plus margin before touching registers
  localparam int CYCLE_LIMIT   = 400_000;  // generous ceiling for the slowest legal run

  // Request code the block must ignore.
  localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

  localparam logic [ENABLE_W-1:0] ALL_ROWS_OFF = '1;

  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [IDX_W-1:0]   idx;
    logic [WORD_W-1:0]  bits;
    logic [LIGHT_W-1:0] light;
  } req_t;

  typedef struct packed {
    logic                shift;
    logic [ENABLE_W-1:0] enables;
    logic                latch;
  } serial_bit_t;

  // One row of the directed sequence: either a register write or a request.
  typedef struct {
    bit                 is_reg;
    logic [2:0]         reg_idx;
    logic [DATA_W-1:0]  reg_value;
    req_t               req;
    bit                 typed;
    logic [WORD_W-1:0]  word;
    logic [IDX_W-1:0]   row;
  } step_t;

  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_BEAT} rx_mode_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ADDR_W-1:0]   paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid;
  logic                in_ready;
  logic [REQ_W-1:0]    req_type;
  logic [IDX_W-1:0]    row_index;
  logic [WORD_W-1:0]   row_bits;
  logic [LIGHT_W-1:0]  light_level;
  logic                out_valid;
  logic                out_ready;
  logic                shift_bit;
  logic [ENABLE_W-1:0] row_enables;
  logic                last;

  // Mirror of the scanner: frame store, scan position, countdown, level, registers.
  logic [WORD_W-1:0]  frame_rows [ROWS];
  logic [IDX_W-1:0]   scan_row;
  logic [PER_W-1:0]   countdown;
  logic [LEVEL_W-1:0] level;
  logic [THR_W-1:0]   thr_bright;
  logic [THR_W-1:0]   thr_dim;
  logic [PER_W-1:0]   period_bright;
  logic [PER_W-1:0]   period_mid;
  logic [PER_W-1:0]   period_dark;

  serial_bit_t expected_bits [$];
  step_t       directed_rows [$];

  int mismatches  = 0;
  int cycle_count = 0;
  int burst_left  = 0;
  bit hold_asked  = 1'b0;
  bit hold_served = 1'b0;

  led_matrix_row_scanner_unit u_dut (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .row_index   (row_index),
    .row_bits    (row_bits),
    .light_level (light_level),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .shift_bit   (shift_bit),
    .row_enables (row_enables),
    .last        (last)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Queue the thirty serial bits of one refresh: MSB first, rows blanked,
  // the final bit latching and pulling the refreshed row's enable low.
  task automatic emit_refresh(input logic [WORD_W-1:0] word, input logic [IDX_W-1:0] row);
    serial_bit_t b;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      b.shift   = word[i];
      b.enables = ALL_ROWS_OFF;
      b.latch   = 1'b0;
      if (i == 0) begin
        b.enables[row] = 1'b0;
        b.latch        = 1'b1;
      end
      expected_bits.push_back(b);
    end
  endtask

  // Advance the mirror by one accepted request; queue its serial bits when
  // emit is set (typed directed rows queue their own).
  task automatic apply_request(input req_t r, input bit emit);
    logic [PER_W-1:0] reload;
    case (r.kind)
      REQ_WRITE: begin
        // Rows beyond the store are dropped.
        if (r.idx < ROWS) frame_rows[r.idx] = r.bits;
      end
      REQ_SAMPLE: begin
        // Bright test first, so reversed thresholds still resolve.
        if (r.light > thr_bright)   level = LEVEL_BRIGHT;
        else if (r.light > thr_dim) level = LEVEL_MID;
        else                        level = LEVEL_DARK;
      end
      REQ_TICK: begin
        if (countdown > 1) begin
          countdown = countdown - 1'b1;
        end else begin
          if (emit) emit_refresh(frame_rows[scan_row], scan_row);
          scan_row = (scan_row == ROWS - 1) ? '0 : scan_row + 1'b1;
          case (level)
            LEVEL_BRIGHT: reload = period_bright;
            LEVEL_MID:    reload = period_mid;
            default:      reload = period_dark;
          endcase
          // A zero period behaves as a single tick.
          countdown = (reload == '0) ? PER_W'(1) : reload;
        end
      end
      default: ;
    endcase
  endtask

  task automatic set_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    case (idx)
      REG_BRIGHT_THR: thr_bright    = value[THR_W-1:0];
      REG_DIM_THR:    thr_dim       = value[THR_W-1:0];
      REG_PERIOD0:    period_bright = value[PER_W-1:0];
      REG_PERIOD1:    period_mid    = value[PER_W-1:0];
      REG_PERIOD2:    period_dark   = value[PER_W-1:0];
      default: ;
    endcase
  endtask

  // Setup cycle then access cycle; the register lands at the access edge.
  task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = ADDR_W'({idx, 2'b00});
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    set_register(idx, value);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // Drop valid, let every queued bit drain, then allow for the pipeline.
  task automatic wait_idle;
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_bits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Bursts of back-to-back transfers separated by random gaps; some bursts
  // follow the previous one with no gap at all.
  task automatic pace_sender;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        in_valid = 1'b0;
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  // Present one request and hold it until the transfer completes.
  task automatic offer(input req_t r, input bit typed,
                       input logic [WORD_W-1:0] word, input logic [IDX_W-1:0] row);
    @(negedge clk);
    req_type    = r.kind;
    row_index   = r.idx;
    row_bits    = r.bits;
    light_level = r.light;
    in_valid    = 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_request(r, !typed);
    if (typed) emit_refresh(word, row);
  endtask

  // Mostly ticks, writes and samples with live content; a few dropped writes
  // and spare codes as noise. Samples favour the current thresholds and extremes.
  task automatic random_request(output req_t r, output bit ignored);
    int pick;
    int v;
    r.kind  = REQ_TICK;
    r.idx   = IDX_W'($urandom);
    r.bits  = WORD_W'($urandom);
    r.light = LIGHT_W'($urandom);
    ignored = 1'b0;
    pick = $urandom_range(99);
    if (pick < 45) begin
      r.kind = REQ_TICK;
    end else if (pick < 72) begin
      r.kind = REQ_WRITE;
      r.idx  = IDX_W'($urandom_range(ROWS - 1));
      case ($urandom_range(3))
        0:       r.bits = '1;
        1:       r.bits = '0;
        default: ;
      endcase
    end else if (pick < 92) begin
      r.kind = REQ_SAMPLE;
      case ($urandom_range(4))
        0: v = int'(thr_bright) + int'($urandom_range(2)) - 1;
        1: v = int'(thr_dim) + int'($urandom_range(2)) - 1;
        2: v = ($urandom_range(1) == 0) ? 0 : 1023;
        default: v = int'(r.light);
      endcase
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      r.light = LIGHT_W'(v);
    end else if (pick < 96) begin
      r.kind  = REQ_WRITE;
      r.idx   = IDX_W'(ROWS);
      ignored = 1'b1;
    end else begin
      r.kind  = REQ_SPARE;
      ignored = 1'b1;
    end
  endtask

  // Program all five registers while idle, then run count live requests.
  // hold_at > 0 asks the receiver for its long hold-off after that many.
  task automatic run_phase(input logic [THR_W-1:0] bright, dim,
                           input logic [PER_W-1:0] p0, p1, p2,
                           input int count, input int hold_at);
    req_t r;
    bit   ignored;
    int   done;
    wait_idle();
    write_register(REG_BRIGHT_THR, DATA_W'(bright));
    write_register(REG_DIM_THR,    DATA_W'(dim));
    write_register(REG_PERIOD0,    DATA_W'(p0));
    write_register(REG_PERIOD1,    DATA_W'(p1));
    write_register(REG_PERIOD2,    DATA_W'(p2));
    done = 0;
    while (done < count) begin
      pace_sender();
      random_request(r, ignored);
      offer(r, 1'b0, '0, '0);
      if (!ignored) done++;
      if (hold_at > 0 && done == hold_at) hold_asked = 1'b1;
    end
  endtask

  function automatic void add_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
    step_t s;
    s = '{default: '0};
    s.is_reg    = 1'b1;
    s.reg_idx   = idx;
    s.reg_value = value;
    directed_rows.push_back(s);
  endfunction

  function automatic void add_req(input logic [REQ_W-1:0] kind, input logic [IDX_W-1:0] idx,
                                  input logic [WORD_W-1:0] bits,
                                  input logic [LIGHT_W-1:0] light,
                                  input bit typed = 1'b0,
                                  input logic [WORD_W-1:0] word = '0,
                                  input logic [IDX_W-1:0] row = '0);
    step_t s;
    s = '{default: '0};
    s.req   = '{kind: kind, idx: idx, bits: bits, light: light};
    s.typed = typed;
    s.word  = word;
    s.row   = row;
    directed_rows.push_back(s);
  endfunction

  // Receiver: rotate through stall patterns, with one long hold-off on request.
  initial begin : receiver
    rx_mode_t mode;
    int       mode_left;
    int       beat;
    out_ready = 1'b0;
    mode      = RX_OPEN;
    mode_left = 0;
    beat      = 0;
    forever begin
      @(negedge clk);
      if (hold_asked && !hold_served) begin
        // Hold off while the sender keeps offering, so the block backs up.
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_served = 1'b1;
      end
      if (mode_left == 0) begin
        mode      = rx_mode_t'($urandom_range(3));
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      beat++;
      case (mode)
        RX_OPEN:   out_ready = 1'b1;
        RX_COIN:   out_ready = 1'($urandom_range(1));
        RX_SPARSE: out_ready = ($urandom_range(3) == 0);
        default:   out_ready = (beat % 3 != 0);
      endcase
    end
  end

  // Score every serial bit transfer against the oldest queued expectation.
  always @(posedge clk) begin : score
    serial_bit_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_bits.size() == 0) begin
        $error("serial bit transfer with nothing expected: shift_bit %0b row_enables %0h last %0b",
               shift_bit, row_enables, last);
        mismatches++;
      end else begin
        want = expected_bits.pop_front();
        if (shift_bit !== want.shift) begin
          $error("shift_bit: expected %0b, got %0b", want.shift, shift_bit);
          mismatches++;
        end
        if (row_enables !== want.enables) begin
          $error("row_enables: expected %0h, got %0h", want.enables, row_enables);
          mismatches++;
        end
        if (last !== want.latch) begin
          $error("last: expected %0b, got %0b", want.latch, last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: a stuck handshake or an undelivered refresh ends here.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("led_matrix_row_scanner_unit_tb: errors");
      $finish;
    end
  end

  initial begin : stimulus
    step_t s;

    rst         = 1'b1;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    in_valid    = 1'b0;
    req_type    = REQ_WRITE;
    row_index   = '0;
    row_bits    = '0;
    light_level = '0;

    // Mirror starts from the reset state.
    foreach (frame_rows[i]) frame_rows[i] = '0;
    scan_row      = '0;
    countdown     = PER_W'(1);
    level         = LEVEL_DARK;
    thr_bright    = RST_BRIGHT_THR;
    thr_dim       = RST_DIM_THR;
    period_bright = RST_PERIOD0;
    period_mid    = RST_PERIOD1;
    period_dark   = RST_PERIOD2;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Short periods first, so the countdown never gets stranded high.
    add_reg(REG_BRIGHT_THR, DATA_W'(950));
    add_reg(REG_DIM_THR,    DATA_W'(800));
    add_reg(REG_PERIOD0,    DATA_W'(3));
    add_reg(REG_PERIOD1,    DATA_W'(2));
    add_reg(REG_PERIOD2,    DATA_W'(1));
    // Countdown is one after reset: the first tick refreshes the cleared row zero.
    add_req(REQ_TICK,   '0, '0, '0, 1'b1, '0, 3'd0);
    add_req(REQ_WRITE,  3'd1, 30'h3FFF_FFFF, '0);
    add_req(REQ_WRITE,  3'd2, 30'h2AAA_AAAA, '0);
    add_req(REQ_TICK,   '0, '0, '0, 1'b1, 30'h3FFF_FFFF, 3'd1);
    // Write beyond the store and a spare code: both dropped.
    add_req(REQ_WRITE,  3'd7, 30'h3FFF_FFFF, '1);
    add_req(REQ_SPARE,  '1, 30'h3FFF_FFFF, '1);
    add_req(REQ_TICK,   '0, '0, '0, 1'b1, 30'h2AAA_AAAA, 3'd2);
    add_req(REQ_SAMPLE, '0, '0, 10'd1023);
    add_req(REQ_TICK,   '0, '0, '0, 1'b1, '0, 3'd3);
    // Ticks that only count down.
    add_req(REQ_TICK,   '1, '1, '1);
    add_req(REQ_TICK,   '0, '0, '0);
    // Samples exactly on each threshold fall to the lower level.
    add_req(REQ_SAMPLE, '0, '0, 10'd950);
    add_req(REQ_TICK,   '0, '0, '0, 1'b1, '0, 3'd4);
    add_req(REQ_SAMPLE, '0, '0, 10'd800);
    add_req(REQ_SAMPLE, '0, '0, 10'd0);
    add_req(REQ_WRITE,  3'd6, 30'h2000_0001, '0);
    add_req(REQ_TICK,   '0, '0, '0);
    add_req(REQ_TICK,   '0, '0, '0, 1'b1, '0, 3'd5);
    add_req(REQ_TICK,   '0, '0, '0, 1'b1, 30'h2000_0001, 3'd6);
    // Row counter wraps back to row zero.
    add_req(REQ_WRITE,  3'd0, 30'h1555_5555, '0);
    add_req(REQ_TICK,   '0, '0, '0, 1'b1, 30'h1555_5555, 3'd0);
    add_req(REQ_SAMPLE, '0, '0, 10'd951);
    add_req(REQ_SAMPLE, '0, '0, 10'd801);
    add_req(REQ_TICK,   '0, '0, '0);

    foreach (directed_rows[i]) begin
      s = directed_rows[i];
      if (s.is_reg) begin
        wait_idle();
        write_register(s.reg_idx, s.reg_value);
      end else begin
        pace_sender();
        offer(s.req, s.typed, s.word, s.row);
      end
    end

    // Reset thresholds, short periods.
    run_phase(10'd950, 10'd800, 17'd2, 17'd3, 17'd1, 50, 0);
    // Thresholds reversed at their extremes.
    run_phase(10'd0, 10'd1023, 17'd1, 17'd4, 17'd2, 50, 0);
    // Opposite extremes, zero periods (one tick each); long hold-off here so
    // every tick expires and the block backs up against the stalled receiver.
    run_phase(10'd1023, 10'd0, 17'd0, 17'd0, 17'd0, 50, 8);
    run_phase(THR_W'($urandom_range(1023)), THR_W'($urandom_range(1023)),
              PER_W'($urandom_range(1, 6)), PER_W'($urandom_range(1, 6)),
              PER_W'($urandom_range(1, 6)), 60, 0);
    // Longest periods last: once loaded, the countdown outlasts the run.
    run_phase(10'd512, 10'd256, 17'd65536, 17'd65536, 17'd1, 25, 0);

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("led_matrix_row_scanner_unit_tb: clean");
    end else begin
      $display("led_matrix_row_scanner_unit_tb: errors");
    end
    $finish;
  end

endmodule
